### rtl/psa_pkg.sv
// Shared types and constants of the packed SIMD ALU.
package psa_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned LANE16_W = 16;
  localparam int unsigned LANE8_W  = 8;
  localparam int unsigned LANES16  = WORD_W / LANE16_W;
  localparam int unsigned LANES8   = WORD_W / LANE8_W;
  localparam int unsigned SHAMT16_W = 8;
  localparam int unsigned SHAMT8_W  = 4;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam mode_t MODE_ADD16 = 3'd0;
  localparam mode_t MODE_SRA16 = 3'd1;
  localparam mode_t MODE_MUL16 = 3'd2;
  localparam mode_t MODE_ADD8  = 3'd3;
  localparam mode_t MODE_SRA8  = 3'd4;
  localparam mode_t MODE_MUL8  = 3'd5;

endpackage

### rtl/psa_in_if.sv
// Operand channel: valid/ready handshake carrying mode and two source words.
interface psa_in_if;
  logic              valid;
  logic              ready;
  psa_pkg::mode_t    mode;
  psa_pkg::word_t    operand_a;
  psa_pkg::word_t    operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input mode, input operand_a, input operand_b,
                  output ready);
endinterface

### rtl/psa_out_if.sv
// Result channel: valid/ready handshake carrying the packed result word.
interface psa_out_if;
  logic              valid;
  logic              ready;
  psa_pkg::word_t    packed_result;

  modport source (output valid, output packed_result, input ready);
  modport sink   (input valid, input packed_result, output ready);
endinterface

### rtl/packed_simd_alu.sv
// Top level of the packed SIMD ALU: operand register, lane datapath, result register.
//
// Usage:
//   operands : sink channel; a transaction carries mode, operand_a and operand_b.
//   result   : source channel; a transaction carries packed_result.
//   Modes: add16, sra16, mul16, add8, sra8, mul8; the two unused codes give zero.
//   Path: an accepted transaction passes two register stages, the operand register
//   and then the result register, before it is offered on result.
//   Throughput: one transaction per cycle while result is taken; the lane datapath
//   between both registers is one pass of adders, shifters, 16x16 / 8x8 multipliers.
//   Stall: when result is not taken, the result register holds and the operand
//   register can still fill; operands.ready drops only when both stages are full.
//   Reset (rst, synchronous, active high) empties both stages; no transaction
//   is in flight afterwards. The block keeps no other state.
//
module packed_simd_alu (
  input  logic      clk,
  input  logic      rst,
  psa_in_if.sink    operands,
  psa_out_if.source result
);
  import psa_pkg::*;

  logic  op_valid;
  mode_t mode_r;
  word_t a_r, b_r;
  logic  res_valid;
  word_t res_r;
  word_t res_next;
  logic  res_load;
  logic  op_load;

  psa_lanes u_lanes (
    .mode          (mode_r),
    .operand_a     (a_r),
    .operand_b     (b_r),
    .packed_result (res_next)
  );

  assign res_load       = op_valid && (!res_valid || result.ready);
  assign operands.ready = !op_valid || res_load;
  assign op_load        = operands.valid && operands.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (operands.ready) begin
      op_valid <= operands.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_load) begin
      mode_r <= operands.mode;
      a_r    <= operands.operand_a;
      b_r    <= operands.operand_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || result.ready) begin
      res_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.packed_result = res_r;

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) rst |=> !op_valid && !res_valid)
    else $error("pipeline not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    op_load |=> op_valid)
    else $error("accepted transaction lost in operand register");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    res_load |=> res_valid && res_r == $past(res_next))
    else $error("result register did not capture datapath output");

  a_stall_holds_ops: assert property (@(posedge clk) disable iff (rst)
    (op_valid && res_valid && !result.ready) |=> op_valid && $stable(a_r) && $stable(b_r))
    else $error("operand register changed while both stages stalled");
`endif

endmodule

### rtl/psa_lanes.sv
// Lane datapath: add, arithmetic shift right and low-half multiply on packed lanes.
module psa_lanes (
  input  psa_pkg::mode_t mode,
  input  psa_pkg::word_t operand_a,
  input  psa_pkg::word_t operand_b,
  output psa_pkg::word_t packed_result
);
  import psa_pkg::*;

  word_t add16, sra16, mul16;
  word_t add8, sra8, mul8;

  logic [SHAMT16_W-1:0] shamt16;
  logic [SHAMT8_W-1:0]  shamt8;

  assign shamt16 = operand_b[SHAMT16_W-1:0];
  assign shamt8  = operand_b[SHAMT8_W-1:0];

  for (genvar i = 0; i < LANES16; i++) begin : g_l16
    logic [LANE16_W-1:0] la, lb;
    logic [LANE16_W-1:0] prod;
    assign la   = operand_a[i*LANE16_W +: LANE16_W];
    assign lb   = operand_b[i*LANE16_W +: LANE16_W];
    // low half of the product is the same for signed and unsigned operands
    assign prod = la * lb;
    assign add16[i*LANE16_W +: LANE16_W] = la + lb;
    // amounts at or past the lane width give sign fill
    assign sra16[i*LANE16_W +: LANE16_W] = (shamt16 >= SHAMT16_W'(LANE16_W)) ?
        {LANE16_W{la[LANE16_W-1]}} : LANE16_W'($signed(la) >>> shamt16[3:0]);
    assign mul16[i*LANE16_W +: LANE16_W] = prod;
  end

  for (genvar i = 0; i < LANES8; i++) begin : g_l8
    logic [LANE8_W-1:0] la, lb;
    logic [LANE8_W-1:0] prod;
    assign la   = operand_a[i*LANE8_W +: LANE8_W];
    assign lb   = operand_b[i*LANE8_W +: LANE8_W];
    assign prod = la * lb;
    assign add8[i*LANE8_W +: LANE8_W] = la + lb;
    assign sra8[i*LANE8_W +: LANE8_W] = (shamt8 >= SHAMT8_W'(LANE8_W)) ?
        {LANE8_W{la[LANE8_W-1]}} : LANE8_W'($signed(la) >>> shamt8[2:0]);
    assign mul8[i*LANE8_W +: LANE8_W] = prod;
  end

  always_comb begin
    case (mode)
      MODE_ADD16: packed_result = add16;
      MODE_SRA16: packed_result = sra16;
      MODE_MUL16: packed_result = mul16;
      MODE_ADD8:  packed_result = add8;
      MODE_SRA8:  packed_result = sra8;
      MODE_MUL8:  packed_result = mul8;
      default:    packed_result = '0;
    endcase
  end

endmodule
